// File: design/planar_row_packbits_decoder_unit_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef PLANAR_ROW_PACKBITS_DECODER_UNIT_MACROS_SVH
`define PLANAR_ROW_PACKBITS_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PRBD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PRBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/prbd_pkg.sv
`timescale 1ns / 1ps

package prbd_pkg;

  // Default and fixed limits of the decoder.
  localparam int MAX_ROW_BYTES_DEF = 256;
  localparam int MAX_PLANES        = 8;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [1:0] REG_PLANE_COUNT = 2'd1;
  localparam logic [1:0] REG_ROW_COUNT   = 2'd2;
  localparam logic [1:0] REG_COMPRESSED  = 2'd3;

  localparam int CFG_DATA_W = 16;

  // Decoder phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LITERAL = 4'b0010,
    PH_RUN     = 4'b0100,
    PH_SKIP    = 4'b1000
  } phase_t;

  // Configuration register contents.
  typedef struct packed {
    logic [8:0]  row_bytes;
    logic [3:0]  plane_count;
    logic [15:0] row_count;
    logic        compressed;
  } cfg_t;

  // One write command.
  typedef struct packed {
    logic [7:0]  value;
    logic [7:0]  repeat_res;
    logic [2:0]  plane;
    logic [15:0] row;
    logic [7:0]  offset;
    logic        row_done;
    logic        image_done;
    logic        overrun;
  } res_t;

endpackage

// File: design/prbd_cfg_regs.sv
`timescale 1ns / 1ps

module prbd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_en,
  input  logic [1:0]                        cfg_addr,
  input  logic [prbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output prbd_pkg::cfg_t                    cfg
);
  import prbd_pkg::*;

  // Register file, written one register per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_bytes   <= 9'd2;
      cfg.plane_count <= 4'd8;
      cfg.row_count   <= 16'd1;
      cfg.compressed  <= 1'b1;
    end else if (cfg_en) begin
      case (cfg_addr)
        REG_ROW_BYTES:   cfg.row_bytes   <= cfg_data[8:0];
        REG_PLANE_COUNT: cfg.plane_count <= cfg_data[3:0];
        REG_ROW_COUNT:   cfg.row_count   <= cfg_data[15:0];
        REG_COMPRESSED:  cfg.compressed  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/prbd_in_reg.sv
`timescale 1ns / 1ps

module prbd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] body_byte,
  input  logic       fire,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // The held byte stalls the sender only when the decoder cannot take it.
  assign in_stall = held_valid & ~fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= body_byte;
    end
  end

endmodule

// File: design/prbd_core.sv
`timescale 1ns / 1ps

module prbd_core #(
  parameter int MAX_ROW_BYTES = prbd_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     byte_in,
  input  prbd_pkg::cfg_t cfg,
  output logic           res_valid,
  output prbd_pkg::res_t res
);
  import prbd_pkg::*;

  localparam int PW  = $clog2(MAX_ROW_BYTES);
  localparam int RBW = $clog2(MAX_ROW_BYTES + 1);
  localparam int CW  = (RBW > 9) ? RBW : 9;
  localparam int SW  = CW + 1;

  phase_t        phase, phase_next;
  logic [7:0]    literal_left, literal_left_next;
  logic [7:0]    run_length, run_length_next;
  logic [PW-1:0] byte_position;
  logic [2:0]    plane_index;
  logic [15:0]   row_index;
  logic          finished;

  logic [CW-1:0] rb_raw, rb_eff, pos_ext, room;
  logic [3:0]    planes_eff;
  logic [15:0]   rows_eff;
  logic [7:0]    lit_left;
  logic          emit_en, emit_over;
  logic [7:0]    emit_n;
  logic [SW-1:0] new_pos;
  logic          wrap, plane_last, row_last;

  // Effective limits, with out-of-range register values saturated.
  always_comb begin
    rb_raw = CW'(cfg.row_bytes);
    if (rb_raw < CW'(2)) begin
      rb_eff = CW'(2);
    end else if (rb_raw > CW'(MAX_ROW_BYTES)) begin
      rb_eff = CW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_raw;
    end
    if (cfg.plane_count == 4'd0) begin
      planes_eff = 4'd1;
    end else if (cfg.plane_count > 4'(MAX_PLANES)) begin
      planes_eff = 4'(MAX_PLANES);
    end else begin
      planes_eff = cfg.plane_count;
    end
    rows_eff = (cfg.row_count == 16'd0) ? 16'd1 : cfg.row_count;
  end

  // Bytes left in the current plane row, never less than one.
  assign pos_ext = CW'(byte_position);
  assign room    = (pos_ext < rb_eff) ? (rb_eff - pos_ext) : CW'(1);
  assign lit_left = (literal_left == 8'd0) ? 8'd0 : (literal_left - 8'd1);

  // Code interpretation for the byte in the input register.
  always_comb begin
    phase_next        = phase;
    literal_left_next = literal_left;
    run_length_next   = run_length;
    emit_en           = 1'b0;
    emit_n            = 8'd1;
    emit_over         = 1'b0;
    if (!finished) begin
      if (!cfg.compressed) begin
        emit_en = 1'b1;
      end else begin
        case (phase)
          PH_HEADER: begin
            if (byte_in inside {[8'd0:8'd127]}) begin
              literal_left_next = byte_in + 8'd1;
              phase_next        = PH_LITERAL;
            end else if (byte_in != 8'd128) begin
              run_length_next = 8'(9'd257 - {1'b0, byte_in});
              phase_next      = PH_RUN;
            end
          end
          PH_LITERAL: begin
            literal_left_next = lit_left;
            emit_en           = 1'b1;
            if (room == CW'(1) && lit_left != 8'd0) begin
              emit_over  = 1'b1;
              phase_next = PH_SKIP;
            end else if (lit_left == 8'd0) begin
              phase_next = PH_HEADER;
            end
          end
          PH_RUN: begin
            emit_en = 1'b1;
            if (CW'(run_length) > room) begin
              emit_n    = 8'(room);
              emit_over = 1'b1;
            end else begin
              emit_n = run_length;
            end
            if (emit_n == 8'd0) begin
              emit_n = 8'd1;
            end
            run_length_next = 8'd0;
            phase_next      = PH_HEADER;
          end
          PH_SKIP: begin
            if (literal_left > 8'd1) begin
              literal_left_next = literal_left - 8'd1;
            end else begin
              literal_left_next = 8'd0;
              phase_next        = PH_HEADER;
            end
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase
      end
    end
  end

  // Position advance and end-of-row / end-of-image detection.
  assign new_pos    = SW'(pos_ext) + SW'(emit_n);
  assign wrap       = new_pos >= SW'(rb_eff);
  assign plane_last = ({1'b0, plane_index} + 4'd1) >= planes_eff;
  assign row_last   = ({1'b0, row_index} + 17'd1) >= {1'b0, rows_eff};

  // Write command for the output register.
  assign res_valid      = fire & emit_en;
  assign res.value      = byte_in;
  assign res.repeat_res = emit_n;
  assign res.plane      = plane_index;
  assign res.row        = row_index;
  assign res.offset     = 8'(byte_position);
  assign res.row_done   = wrap & plane_last;
  assign res.image_done = wrap & plane_last & row_last;
  assign res.overrun    = emit_over;

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      literal_left  <= 8'd0;
      run_length    <= 8'd0;
      byte_position <= '0;
      plane_index   <= 3'd0;
      row_index     <= 16'd0;
      finished      <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      literal_left <= literal_left_next;
      run_length   <= run_length_next;
      if (emit_en) begin
        if (wrap) begin
          byte_position <= '0;
          if (plane_last) begin
            plane_index <= 3'd0;
            if (row_last) begin
              finished <= 1'b1;
            end else begin
              row_index <= row_index + 16'd1;
            end
          end else begin
            plane_index <= plane_index + 3'd1;
          end
        end else begin
          byte_position <= PW'(new_pos);
        end
      end
    end
  end

endmodule

// File: design/prbd_out_reg.sv
`timescale 1ns / 1ps

module prbd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic           res_valid,
  input  prbd_pkg::res_t res,
  output logic           out_valid,
  input  logic           out_stall,
  output prbd_pkg::res_t held
);

  // Valid follows the decoder when it steps, and drops when a transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res_valid;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

endmodule

// File: design/planar_row_packbits_decoder_unit.sv
`timescale 1ns / 1ps

// Planar row PackBits decoder.
// Input channel: in_valid / in_stall carry one body byte per transaction.
// Output channel: out_valid / out_stall carry one write command
// (value, repeat_res, plane, row, offset, flags); a byte yields zero or one.
// Configuration: cfg_en writes cfg_data into register cfg_addr
// (row_bytes, plane_count, row_count, compressed); the user must write only while idle (not enforced).
// Path: a byte accepted into the input register is decoded when the decoder steps,
// and its command is loaded into the output register at that step.
// Throughput: one byte per cycle while the output is not stalled; the decoder
// state is updated in the single stage between the input and output registers.
// Stall: while the output command waits, the byte in the input register is
// held and in_stall goes high; a new byte is taken again as soon as the
// output register is emptied or being emptied in the same cycle.
// Reset: synchronous; clears both registers' valid flags, the decoder state
// (expect header, position, plane and row zero) and loads the register
// defaults. After the final row's last write, further bytes are consumed
// with no command until the next reset.
module planar_row_packbits_decoder_unit #(
  parameter int MAX_ROW_BYTES = prbd_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [1:0]                      cfg_addr,
  input  logic [prbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      body_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      value,
  output logic [7:0]                      repeat_res,
  output logic [2:0]                      plane,
  output logic [15:0]                     row,
  output logic [7:0]                      offset,
  output logic                            row_done,
  output logic                            image_done,
  output logic                            overrun
);
  import prbd_pkg::*;

  cfg_t       cfg;
  res_t       res, held;
  logic       held_valid, fire, res_valid;
  logic [7:0] held_byte;

  // The decoder steps when a byte is held and the output register can take a result.
  assign fire = held_valid & (~out_valid | ~out_stall);

  prbd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_en   (cfg_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  prbd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .body_byte  (body_byte),
    .fire       (fire),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  prbd_core #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .byte_in   (held_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  prbd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign value      = held.value;
  assign repeat_res = held.repeat_res;
  assign plane      = held.plane;
  assign row        = held.row;
  assign offset     = held.offset;
  assign row_done   = held.row_done;
  assign image_done = held.image_done;
  assign overrun    = held.overrun;

endmodule

// File: design/prbd_checker.sv
`timescale 1ns / 1ps

`include "planar_row_packbits_decoder_unit_macros.svh"

module prbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] value,
  input logic [7:0] repeat_res,
  input logic       row_done,
  input logic       image_done
);

  // A stalled command stays on the port unchanged.
  `PRBD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(value) && $stable(repeat_res), "stalled output command changed")

  // Every write covers between one and 128 bytes.
  `PRBD_ASSERT_NOW(a_repeat_range, clk, rst, out_valid, repeat_res != 8'd0 && repeat_res <= 8'd128, "repeat count out of range")

  // The end of the image is always also the end of a row.
  `PRBD_ASSERT_NOW(a_image_row, clk, rst, out_valid && image_done, row_done, "image_done without row_done")

  // Once the final write has gone out, no further command appears.
  `PRBD_ASSERT_NEXT(a_after_image, clk, rst, out_valid && !out_stall && image_done, !out_valid, "command after end of image")

endmodule

bind planar_row_packbits_decoder_unit prbd_checker u_prbd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .value      (value),
  .repeat_res (repeat_res),
  .row_done   (row_done),
  .image_done (image_done)
);

// File: tb/prbd_write_checker.sv
`timescale 1ns / 1ps

module prbd_write_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [1:0]                      cfg_addr,
  input  logic [prbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      body_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      value,
  input  logic [7:0]                      repeat_res,
  input  logic [2:0]                      plane,
  input  logic [15:0]                     row,
  input  logic [7:0]                      offset,
  input  logic                            row_done,
  input  logic                            image_done,
  input  logic                            overrun,
  output int                              fail_count,
  output int                              pending_writes
);
  import prbd_pkg::*;

  // Shadow copy of the configuration registers.
  logic [8:0]  cur_row_bytes;
  logic [3:0]  cur_planes;
  logic [15:0] cur_rows;
  logic        cur_compressed;

  // Shadow copy of the decoder state.
  phase_t dec_phase;
  int     lit_left;
  int     run_len;
  int     byte_pos;
  int     plane_idx;
  int     row_idx;
  bit     image_finished;

  // Write commands predicted but not yet seen on the output channel.
  res_t expected_writes[$];

  // Register values as the decoder uses them, after saturation.
  function automatic int row_len();
    if (cur_row_bytes < 2) return 2;
    if (cur_row_bytes > MAX_ROW_BYTES_DEF) return MAX_ROW_BYTES_DEF;
    return int'(cur_row_bytes);
  endfunction

  function automatic int plane_total();
    if (cur_planes < 1) return 1;
    if (cur_planes > MAX_PLANES) return MAX_PLANES;
    return int'(cur_planes);
  endfunction

  function automatic int row_total();
    return (cur_rows == 0) ? 1 : int'(cur_rows);
  endfunction

  // Bytes left in the current plane row; a position past the end counts as one.
  function automatic int room_in_row();
    return (byte_pos < row_len()) ? row_len() - byte_pos : 1;
  endfunction

  // Build a write at the current position and advance by n bytes,
  // stepping plane, row and image as the row end is reached.
  function automatic res_t issue_write(input logic [7:0] val, input int n, input bit over);
    res_t w;
    w.value      = val;
    w.repeat_res = n[7:0];
    w.plane      = plane_idx[2:0];
    w.row        = row_idx[15:0];
    w.offset     = byte_pos[7:0];
    w.row_done   = 1'b0;
    w.image_done = 1'b0;
    w.overrun    = over;
    byte_pos += n;
    if (byte_pos >= row_len()) begin
      byte_pos = 0;
      if (plane_idx + 1 >= plane_total()) begin
        plane_idx  = 0;
        w.row_done = 1'b1;
        if (row_idx + 1 >= row_total()) begin
          w.image_done   = 1'b1;
          image_finished = 1'b1;
        end else begin
          row_idx = (row_idx + 1) & 16'hFFFF;
        end
      end else begin
        plane_idx = (plane_idx + 1) & 7;
      end
    end
    return w;
  endfunction

  // Decode one body byte; returns 1 when it yields a write command.
  function automatic bit decode_byte(input logic [7:0] b, output res_t w);
    int left;
    int room;
    int n;
    bit over;
    w = '0;
    if (image_finished) return 1'b0;
    if (!cur_compressed) begin
      w = issue_write(b, 1, 1'b0);
      return 1'b1;
    end
    case (dec_phase)
      PH_HEADER: begin
        if (b < 8'd128) begin
          lit_left  = int'(b) + 1;
          dec_phase = PH_LITERAL;
        end else if (b != 8'd128) begin
          // Signed -1..-127 repeats the next byte 2..128 times.
          run_len   = 1 + (256 - int'(b));
          dec_phase = PH_RUN;
        end
        return 1'b0;
      end
      PH_LITERAL: begin
        left     = (lit_left == 0) ? 0 : lit_left - 1;
        lit_left = left;
        if (room_in_row() == 1 && left > 0) begin
          // Literal runs past the row end: flag it and drop the rest.
          w         = issue_write(b, 1, 1'b1);
          dec_phase = PH_SKIP;
          return 1'b1;
        end
        w = issue_write(b, 1, 1'b0);
        if (left == 0) dec_phase = PH_HEADER;
        return 1'b1;
      end
      PH_RUN: begin
        room = room_in_row();
        n    = run_len;
        over = 1'b0;
        if (n > room) begin
          n    = room;
          over = 1'b1;
        end
        if (n == 0) n = 1;
        dec_phase = PH_HEADER;
        run_len   = 0;
        w = issue_write(b, n, over);
        return 1'b1;
      end
      default: begin
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) dec_phase = PH_HEADER;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin : watch
    res_t want;
    res_t next_write;
    if (rst) begin
      cur_row_bytes  = 9'd2;
      cur_planes     = 4'd8;
      cur_rows       = 16'd1;
      cur_compressed = 1'b1;
      dec_phase      = PH_HEADER;
      lit_left       = 0;
      run_len        = 0;
      byte_pos       = 0;
      plane_idx      = 0;
      row_idx        = 0;
      image_finished = 1'b0;
      fail_count     = 0;
      expected_writes.delete();
    end else begin
      // Output transaction: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $error("write command with none expected: value %0d row %0d offset %0d",
                 value, row, offset);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          check_field("value", 16'(want.value), 16'(value));
          check_field("repeat_res", 16'(want.repeat_res), 16'(repeat_res));
          check_field("plane", 16'(want.plane), 16'(plane));
          check_field("row", want.row, row);
          check_field("offset", 16'(want.offset), 16'(offset));
          check_field("row_done", 16'(want.row_done), 16'(row_done));
          check_field("image_done", 16'(want.image_done), 16'(image_done));
          check_field("overrun", 16'(want.overrun), 16'(overrun));
        end
      end
      // Register writes take effect at once.
      if (cfg_en) begin
        case (cfg_addr)
          REG_ROW_BYTES:   cur_row_bytes  = cfg_data[8:0];
          REG_PLANE_COUNT: cur_planes     = cfg_data[3:0];
          REG_ROW_COUNT:   cur_rows       = cfg_data[15:0];
          REG_COMPRESSED:  cur_compressed = cfg_data[0];
          default: ;
        endcase
      end
      // Input transaction: predict what this byte writes.
      if (in_valid && !in_stall) begin
        if (decode_byte(body_byte, next_write)) expected_writes.push_back(next_write);
      end
    end
    pending_writes <= expected_writes.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import prbd_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_en    = 1'b0;
  logic [1:0]            cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [7:0]            body_byte = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [7:0]            value;
  logic [7:0]            repeat_res;
  logic [2:0]            plane;
  logic [15:0]           row;
  logic [7:0]            offset;
  logic                  row_done;
  logic                  image_done;
  logic                  overrun;

  int fail_count;
  int pending_writes;

  // Idling percentages and the long receiver hold-off request.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_ticket   = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int bytes_sent    = 0;

  // Register settings of the random phases.
  int rb_list[12]   = '{2, 256, 3, 16, 511, 0, 40, 256, 7, 2, 100, 9};
  int pc_list[12]   = '{1, 8, 3, 4, 15, 0, 5, 1, 8, 8, 2, 6};
  int rows_list[12] = '{65535, 65535, 30000, 65535, 4000, 65535,
                        20000, 65535, 65535, 30000, 65535, 65535};
  int comp_list[12] = '{1, 1, 1, 0, 1, 1, 1, 0, 1, 0, 1, 1};

  planar_row_packbits_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .body_byte (body_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .repeat_res(repeat_res),
    .plane     (plane),
    .row       (row),
    .offset    (offset),
    .row_done  (row_done),
    .image_done(image_done),
    .overrun   (overrun)
  );

  prbd_write_checker write_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_en        (cfg_en),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .body_byte     (body_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .value         (value),
    .repeat_res    (repeat_res),
    .plane         (plane),
    .row           (row),
    .offset        (offset),
    .row_done      (row_done),
    .image_done    (image_done),
    .overrun       (overrun),
    .fail_count    (fail_count),
    .pending_writes(pending_writes)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left   <= 90;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Register write, with cfg_en dropped again before the task returns.
  task automatic write_reg(input logic [1:0] idx, input int data);
    cfg_en   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait until every predicted write has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One input transaction, with random sender gaps ahead of it.
  task automatic push_byte(input logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    body_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // One code: mostly literals and runs with random content, some no-ops and noise.
  task automatic push_code();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 45) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(15);
      push_byte(len[7:0]);
      repeat (len + 1) push_byte(8'($urandom_range(255)));
    end else if (pick < 80) begin
      push_byte(8'($urandom_range(255, 129)));
      push_byte(8'($urandom_range(255)));
    end else if (pick < 85) begin
      push_byte(8'h80);
    end else begin
      push_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 45;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 45;
      end
      default: begin
        send_idle_pct = 7;
        stall_pct     = 7;
      end
    endcase
  endtask

  // Run limit.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [7:0] directed[16];
    int target;
    int waited;
    bit paused;
    directed = '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'hAA, 8'h81, 8'h55, 8'h05,
                 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h00, 8'h7E};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: shortest literal, no-op, shortest and longest run with clipping,
    // and a literal that runs past the row end.
    write_reg(REG_ROW_COUNT, 65535);
    write_reg(REG_ROW_BYTES, 4);
    write_reg(REG_PLANE_COUNT, 2);
    write_reg(REG_COMPRESSED, 1);
    foreach (directed[i]) push_byte(directed[i]);

    // Mode switched in the middle of a literal: raw bytes leave it pending.
    wait_idle();
    push_byte(8'h03);
    push_byte(8'h11);
    wait_idle();
    write_reg(REG_COMPRESSED, 0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h33);
    wait_idle();
    write_reg(REG_COMPRESSED, 1);
    push_byte(8'h44);
    push_byte(8'h55);
    push_byte(8'h66);
    push_byte(8'h80);

    // Random phases over several register settings and idling patterns.
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      write_reg(REG_ROW_BYTES, rb_list[p]);
      write_reg(REG_PLANE_COUNT, pc_list[p]);
      write_reg(REG_ROW_COUNT, rows_list[p]);
      write_reg(REG_COMPRESSED, comp_list[p]);
      set_idling(p % 4);
      if (p % 4 == 0) hold_ticket <= hold_ticket + 1;
      paused = 1'b0;
      target = bytes_sent + 65;
      while (bytes_sent < target) begin
        push_code();
        // Let the block drain completely in the middle of some phases.
        if (!paused && p % 3 == 1 && bytes_sent >= target - 45) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    // Final phase: a row limit of zero ends the image at the next row end;
    // everything after that must be swallowed.
    wait_idle();
    write_reg(REG_ROW_BYTES, 3);
    write_reg(REG_PLANE_COUNT, 2);
    write_reg(REG_ROW_COUNT, 1);
    write_reg(REG_ROW_COUNT, 0);
    write_reg(REG_COMPRESSED, 1);
    set_idling(3);
    target = bytes_sent + 45;
    while (bytes_sent < target) push_code();

    // Wait for the last writes, with a bound, then let the pipeline settle.
    in_valid <= 1'b0;
    waited = 0;
    repeat (2) @(posedge clk);
    while (pending_writes != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_writes == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: planar_row_packbits_decoder_unit.f
+incdir+design
design/prbd_pkg.sv
design/prbd_cfg_regs.sv
design/prbd_in_reg.sv
design/prbd_core.sv
design/prbd_out_reg.sv
design/planar_row_packbits_decoder_unit.sv
design/prbd_checker.sv
tb/prbd_write_checker.sv
tb/tb.sv
